FILE: sv/wsdf_pkg.sv
package wsdf_pkg;

   // default width of the per-frame payload index
   localparam int INDEX_WIDTH_DEF = 16;

   // configuration reset value
   localparam logic [15:0] MAX_TEXT_LEN_RST = 16'd4095;

   // frame opcodes
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   // short length codes that select an extended length
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // extended length and mask key byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] MASK_BYTES  = 4'd4;

   // result event kinds
   localparam logic [1:0] EV_TEXT  = 2'd0;
   localparam logic [1:0] EV_EMPTY = 2'd1;
   localparam logic [1:0] EV_PING  = 2'd2;
   localparam logic [1:0] EV_CLOSE = 2'd3;

   // parser phases
   typedef enum logic [6:0] {
      PH_OPCODE  = 7'b0000001,
      PH_LENGTH  = 7'b0000010,
      PH_EXT16   = 7'b0000100,
      PH_EXT64   = 7'b0001000,
      PH_MASK    = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_CLOSED  = 7'b1000000
   } phase_type;

endpackage

FILE: sv/websocket_frame_deframer_top.sv
// Channel  | Direction | Ports                                     | Handshake
// req      | in        | req_rx_byte                               | req_valid / req_stall
// rsp      | out       | rsp_event_kind, rsp_data_byte,            | rsp_valid / rsp_stall
//          |           | rsp_last_of_frame, rsp_truncated          |
// csr      | in        | csr_max_text_len                          | csr_valid / csr_ready
//
// One byte per clock is sustained while rsp does not stall; a byte waits in the input
// register and its event, if any, is loaded into the result register as the byte leaves.
// The rate is set by the single parse step between the input and result registers.
// Reset is synchronous and active high; it clears the parser and sets max_text_len to 4095.
// A stall on rsp holds the result register and, through it, backs up into req_stall.
module websocket_frame_deframer_top #(
   parameter int INDEX_WIDTH = wsdf_pkg::INDEX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_of_frame,
   output logic        rsp_truncated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_text_len
);
   import wsdf_pkg::*;

   localparam int LIM_W = 33;

   // configuration
   logic [15:0]            max_len_ff;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;

   // parser state
   phase_type              phase_ff, phase_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   mask_on_ff, mask_on_in;
   logic [3:0]             hcnt_ff, hcnt_in;
   logic [31:0]            mask_key_ff, mask_key_in;
   logic [63:0]            rem_ff, rem_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                   trunc_ff, trunc_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             out_kind_ff;
   logic [7:0]             out_data_ff;
   logic                   out_last_ff;
   logic                   out_trunc_ff;

   // step results
   logic                   res_valid;
   logic [1:0]             res_kind;
   logic [7:0]             res_data;
   logic                   res_last;
   logic                   res_trunc;
   logic                   hdr_end;
   logic                   advance;

   // effective limit
   logic [15:0]            lim16;
   logic [LIM_W-1:0]       lim_wide;
   logic [LIM_W-1:0]       idx_max_wide;
   logic [LIM_W-1:0]       lim_clamp;
   logic [INDEX_WIDTH-1:0] eff_limit;

   // payload helpers
   logic [63:0]            rem_dec;
   logic                   deliver;
   logic [7:0]             key_byte;

   assign csr_ready = 1'b1;

   // hold the limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_TEXT_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_text_len;
      end
   end

   // clamp the limit to [1, 2^INDEX_WIDTH - 1]
   always_comb begin
      lim16        = (max_len_ff == 16'd0) ? 16'd1 : max_len_ff;
      lim_wide     = {{(LIM_W-16){1'b0}}, lim16};
      idx_max_wide = (LIM_W'(1) << INDEX_WIDTH) - LIM_W'(1);
      lim_clamp    = (lim_wide > idx_max_wide) ? idx_max_wide : lim_wide;
      eff_limit    = lim_clamp[INDEX_WIDTH-1:0];
   end

   // move a word from the input register when the result register can take it
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // payload byte helpers
   always_comb begin
      rem_dec = rem_ff - 64'd1;
      deliver = (opcode_ff == OP_TEXT) && (!trunc_ff || (idx_ff < eff_limit));
      case (idx_ff[1:0])
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // parse one byte
   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      mask_on_in  = mask_on_ff;
      hcnt_in     = hcnt_ff;
      mask_key_in = mask_key_ff;
      rem_in      = rem_ff;
      idx_in      = idx_ff;
      trunc_in    = trunc_ff;
      res_valid   = 1'b0;
      res_kind    = EV_TEXT;
      res_data    = 8'd0;
      res_last    = 1'b0;
      res_trunc   = 1'b0;
      hdr_end     = 1'b0;

      unique case (phase_ff)
         PH_OPCODE: begin
            opcode_in   = in_byte_ff[3:0];
            mask_key_in = 32'd0;
            phase_in    = PH_LENGTH;
         end
         PH_LENGTH: begin
            mask_on_in = in_byte_ff[7];
            hcnt_in    = 4'd0;
            if (in_byte_ff[6:0] == LEN_EXT16) begin
               rem_in   = 64'd0;
               phase_in = PH_EXT16;
            end else if (in_byte_ff[6:0] == LEN_EXT64) begin
               rem_in   = 64'd0;
               phase_in = PH_EXT64;
            end else begin
               rem_in = {57'd0, in_byte_ff[6:0]};
               if (in_byte_ff[7]) begin
                  phase_in = PH_MASK;
               end else begin
                  hdr_end = 1'b1;
               end
            end
         end
         PH_EXT16, PH_EXT64: begin
            rem_in  = {rem_ff[55:0], in_byte_ff};
            hcnt_in = hcnt_ff + 4'd1;
            if (hcnt_in == ((phase_ff == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
               hcnt_in = 4'd0;
               if (mask_on_ff) begin
                  phase_in = PH_MASK;
               end else begin
                  hdr_end = 1'b1;
               end
            end
         end
         PH_MASK: begin
            mask_key_in = {mask_key_ff[23:0], in_byte_ff};
            hcnt_in     = hcnt_ff + 4'd1;
            if (hcnt_in == MASK_BYTES) begin
               hdr_end = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            rem_in = rem_dec;
            if (deliver) begin
               res_valid = 1'b1;
               res_kind  = EV_TEXT;
               res_data  = in_byte_ff ^ key_byte;
               res_last  = (rem_dec == 64'd0) ||
                           (trunc_ff && (({1'b0, idx_ff} + 1'b1) == {1'b0, eff_limit}));
               res_trunc = trunc_ff;
               if (idx_ff != {INDEX_WIDTH{1'b1}}) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (rem_dec == 64'd0) begin
               phase_in = PH_OPCODE;
            end
         end
         PH_CLOSED: begin
            phase_in = PH_CLOSED;
         end
         default: begin
            phase_in = PH_OPCODE;
         end
      endcase

      // finish the header: pick the next phase and any frame event
      if (hdr_end) begin
         idx_in   = '0;
         trunc_in = 1'b0;
         hcnt_in  = 4'd0;
         if (opcode_ff == OP_CLOSE) begin
            phase_in  = PH_CLOSED;
            res_valid = 1'b1;
            res_kind  = EV_CLOSE;
            res_last  = 1'b1;
         end else begin
            phase_in = (rem_in != 64'd0) ? PH_PAYLOAD : PH_OPCODE;
            if (opcode_ff == OP_PING) begin
               res_valid = 1'b1;
               res_kind  = EV_PING;
               res_last  = 1'b1;
            end else if (opcode_ff == OP_TEXT) begin
               if (rem_in == 64'd0) begin
                  res_valid = 1'b1;
                  res_kind  = EV_EMPTY;
                  res_last  = 1'b1;
               end else begin
                  trunc_in = rem_in > {{(64-INDEX_WIDTH){1'b0}}, eff_limit};
               end
            end
         end
      end
   end

   // advance the parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OPCODE;
         opcode_ff   <= 4'd0;
         mask_on_ff  <= 1'b0;
         hcnt_ff     <= 4'd0;
         mask_key_ff <= 32'd0;
         rem_ff      <= 64'd0;
         idx_ff      <= '0;
         trunc_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         mask_on_ff  <= mask_on_in;
         hcnt_ff     <= hcnt_in;
         mask_key_ff <= mask_key_in;
         rem_ff      <= rem_in;
         idx_ff      <= idx_in;
         trunc_ff    <= trunc_in;
      end
   end

   // load or drain the result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && res_valid) begin
         out_kind_ff  <= res_kind;
         out_data_ff  <= res_data;
         out_last_ff  <= res_last;
         out_trunc_ff <= res_trunc;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_kind_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_last_of_frame = out_last_ff;
   assign rsp_truncated     = out_trunc_ff;

   // checks
   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED |=> phase_ff == PH_CLOSED)
      else $error("parser left the closed phase without reset");

   a_hcnt_range: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= EXT64_BYTES)
      else $error("header byte count out of range");

   a_trunc_text_only: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_trunc_ff |-> out_kind_ff == EV_TEXT)
      else $error("truncated flag on a non-text event");

   a_event_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff != EV_TEXT |-> out_last_ff && out_data_ff == 8'd0)
      else $error("frame event without last flag or with data");

   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED && !(out_valid_ff && !rsp_stall) |=> out_valid_ff == $past(out_valid_ff))
      else $error("result produced after close");

endmodule

FILE: sim/websocket_frame_deframer_checker.sv
`timescale 1ns / 100ps

module websocket_frame_deframer_checker #(
   parameter int INDEX_WIDTH = wsdf_pkg::INDEX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_event_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_last_of_frame,
   input  logic        rsp_truncated,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_max_text_len,
   output int          fail_count,
   output int          pending,
   output int          events_checked
);
   import wsdf_pkg::*;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       cut;
   } frame_event_type;

   localparam logic [63:0] INDEX_MAX = (64'd1 << INDEX_WIDTH) - 64'd1;

   // expected events, oldest first
   frame_event_type events_due[$];
   frame_event_type want;

   // parser copy
   logic [15:0] text_limit;
   phase_type   phase;
   logic [3:0]  opcode;
   logic        masked;
   logic [3:0]  hdr_count;
   logic [31:0] mask_key;
   logic [63:0] remaining;
   logic [63:0] text_index;
   logic        text_cut;

   // zero acts as one; clamp to what the index can count
   function automatic logic [63:0] delivery_limit();
      logic [63:0] lim;
      lim = {48'd0, text_limit};
      if (lim == 64'd0) lim = 64'd1;
      if (lim > INDEX_MAX) lim = INDEX_MAX;
      return lim;
   endfunction

   // header complete: raise close, ping or empty-text event, decide truncation
   task automatic close_header();
      text_index = 64'd0;
      text_cut   = 1'b0;
      hdr_count  = 4'd0;
      if (opcode == OP_CLOSE) begin
         phase = PH_CLOSED;
         events_due.push_back(frame_event_type'({EV_CLOSE, 8'h00, 1'b1, 1'b0}));
      end else begin
         phase = (remaining != 64'd0) ? PH_PAYLOAD : PH_OPCODE;
         if (opcode == OP_PING) begin
            events_due.push_back(frame_event_type'({EV_PING, 8'h00, 1'b1, 1'b0}));
         end else if (opcode == OP_TEXT) begin
            if (remaining == 64'd0)
               events_due.push_back(frame_event_type'({EV_EMPTY, 8'h00, 1'b1, 1'b0}));
            else
               text_cut = (remaining > delivery_limit());
         end
      end
   endtask

   // length complete: go collect the mask key or finish the header
   task automatic close_length();
      hdr_count = 4'd0;
      if (masked)
         phase = PH_MASK;
      else
         close_header();
   endtask

   // advance the parser by one received word
   task automatic parse_rx_byte(input logic [7:0] b);
      logic [63:0] lim;
      logic [7:0]  key_byte;
      logic        last;
      case (phase)
         PH_OPCODE: begin
            opcode   = b[3:0];
            mask_key = 32'd0;
            phase    = PH_LENGTH;
         end
         PH_LENGTH: begin
            masked    = b[7];
            remaining = {57'd0, b[6:0]};
            hdr_count = 4'd0;
            if (b[6:0] == LEN_EXT16) begin
               remaining = 64'd0;
               phase     = PH_EXT16;
            end else if (b[6:0] == LEN_EXT64) begin
               remaining = 64'd0;
               phase     = PH_EXT64;
            end else begin
               close_length();
            end
         end
         PH_EXT16, PH_EXT64: begin
            remaining = {remaining[55:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count == ((phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
               close_length();
         end
         PH_MASK: begin
            mask_key  = {mask_key[23:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count == MASK_BYTES)
               close_header();
         end
         PH_PAYLOAD: begin
            remaining = remaining - 64'd1;
            lim       = delivery_limit();
            if (opcode == OP_TEXT && (!text_cut || text_index < lim)) begin
               key_byte = mask_key[8 * (3 - text_index[1:0]) +: 8];
               last     = (remaining == 64'd0) || (text_cut && text_index + 64'd1 == lim);
               events_due.push_back(frame_event_type'({EV_TEXT, b ^ key_byte, last, text_cut}));
               if (text_index < INDEX_MAX) text_index = text_index + 64'd1;
            end
            if (remaining == 64'd0) phase = PH_OPCODE;
         end
         default: begin
            // closed: drop everything
         end
      endcase
   endtask

   task automatic compare_field(input string field, input logic [7:0] want_v,
                                input logic [7:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
         fail_count++;
      end
   endtask

   // watch all three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         text_limit     = MAX_TEXT_LEN_RST;
         phase          = PH_OPCODE;
         opcode         = 4'd0;
         masked         = 1'b0;
         hdr_count      = 4'd0;
         mask_key       = 32'd0;
         remaining      = 64'd0;
         text_index     = 64'd0;
         text_cut       = 1'b0;
         fail_count     = 0;
         events_checked = 0;
         events_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            text_limit = csr_max_text_len;
         if (req_valid && !req_stall)
            parse_rx_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (events_due.size() == 0) begin
               $display("%0t: result with none expected, kind %0d data %0d",
                        $time, rsp_event_kind, rsp_data_byte);
               fail_count++;
            end else begin
               want = events_due.pop_front();
               compare_field("event_kind", 8'(want.kind), 8'(rsp_event_kind));
               compare_field("data_byte", want.data, rsp_data_byte);
               compare_field("last_of_frame", 8'(want.last), 8'(rsp_last_of_frame));
               compare_field("truncated", 8'(want.cut), 8'(rsp_truncated));
               events_checked++;
            end
         end
      end
      pending = events_due.size();
   end

endmodule

FILE: sim/websocket_frame_deframer_top_test.sv
`timescale 1ns / 100ps

module websocket_frame_deframer_top_test;
   import wsdf_pkg::*;

   localparam int IDX_W         = INDEX_WIDTH_DEF;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_BYTES  = 950;
   localparam int PHASE_BYTES   = 150;

   // length encodings
   localparam int FORM_SHORT = 0;
   localparam int FORM_EXT16 = 1;
   localparam int FORM_EXT64 = 2;

   // opcodes the block skips
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_PONG   = 4'hA;

   typedef logic [7:0] octet_queue_type[$];

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_of_frame;
   logic        rsp_truncated;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_max_text_len;

   int fail_count;
   int pending;
   int events_checked;
   int cycle_count  = 0;
   int bytes_sent   = 0;
   int frames_sent  = 0;
   int limit_writes = 0;
   bit calm         = 1'b0;

   websocket_frame_deframer_top #(.INDEX_WIDTH(IDX_W)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_truncated     (rsp_truncated),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_text_len  (csr_max_text_len)
   );

   websocket_frame_deframer_checker #(.INDEX_WIDTH(IDX_W)) frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_truncated     (rsp_truncated),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_text_len  (csr_max_text_len),
      .fail_count        (fail_count),
      .pending           (pending),
      .events_checked    (events_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stall the result side now and then
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Stopped at the cycle limit with %0d results outstanding", pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   // assemble one frame: opcode word, length words, optional key, random payload
   function automatic octet_queue_type build_frame(input logic [3:0] op, input logic [63:0] len,
                                                   input int form, input bit with_mask);
      octet_queue_type q;
      logic [3:0]      flags;
      logic [31:0]     key;
      flags = 4'($urandom_range(0, 15));
      key   = $urandom;
      q.push_back({flags, op});
      case (form)
         FORM_SHORT: q.push_back({with_mask, len[6:0]});
         FORM_EXT16: begin
            q.push_back({with_mask, LEN_EXT16});
            q.push_back(len[15:8]);
            q.push_back(len[7:0]);
         end
         default: begin
            q.push_back({with_mask, LEN_EXT64});
            for (int i = 7; i >= 0; i--) q.push_back(len[8 * i +: 8]);
         end
      endcase
      if (with_mask)
         for (int i = 3; i >= 0; i--) q.push_back(key[8 * i +: 8]);
      for (longint n = 0; n < len; n++) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   // send words first..stop-1, idling at random; hold each word until taken
   task automatic send_span(input octet_queue_type q, input int first, input int stop);
      for (int i = first; i < stop; i++) begin
         while (!calm && $urandom_range(0, 99) < 7) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= q[i];
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
   endtask

   task automatic send_frame(input logic [3:0] op, input logic [63:0] len,
                             input int form, input bit with_mask);
      octet_queue_type q;
      q = build_frame(op, len, form, with_mask);
      send_span(q, 0, q.size());
      frames_sent++;
   endtask

   // hold off until every expected event is out, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      drain();
      csr_valid        <= 1'b1;
      csr_max_text_len <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_writes++;
   endtask

   initial begin : stimulus
      octet_queue_type q;
      logic [3:0]      op;
      logic [63:0]     len;
      logic [15:0]     lim;
      int              form;
      int              pick;
      int              phase_no;
      int              phase_start;
      int              random_start;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = 8'h00;
      csr_valid        = 1'b0;
      csr_max_text_len = 16'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty text, plain and masked (event lands on the last key word)
      send_frame(OP_TEXT, 0, FORM_SHORT, 1'b0);
      send_frame(OP_TEXT, 0, FORM_SHORT, 1'b1);
      // short text, plain and masked
      send_frame(OP_TEXT, 3, FORM_SHORT, 1'b0);
      send_frame(OP_TEXT, 5, FORM_SHORT, 1'b1);
      // ping with skipped payload, and an empty ping with a wide length
      send_frame(OP_PING, 4, FORM_SHORT, 1'b1);
      send_frame(OP_PING, 0, FORM_EXT64, 1'b0);
      // opcodes that are skipped silently
      send_frame(OP_BINARY, 3, FORM_SHORT, 1'b0);
      send_frame(OP_PONG, 2, FORM_EXT16, 1'b1);
      // longest short length, non-minimal extended lengths, a longer frame
      send_frame(OP_TEXT, 125, FORM_SHORT, 1'b1);
      send_frame(OP_TEXT, 2, FORM_EXT16, 1'b0);
      send_frame(OP_TEXT, 1, FORM_EXT64, 1'b1);
      send_frame(OP_TEXT, 300, FORM_EXT16, 1'b1);

      // zero limit behaves as one
      write_limit(16'd0);
      send_frame(OP_TEXT, 3, FORM_SHORT, 1'b1);
      send_frame(OP_TEXT, 1, FORM_SHORT, 1'b0);

      // exactly at the limit, then one past it
      write_limit(16'd2);
      send_frame(OP_TEXT, 2, FORM_SHORT, 1'b1);
      send_frame(OP_TEXT, 3, FORM_SHORT, 1'b1);

      // raise the limit in the middle of a truncated frame
      write_limit(16'd3);
      q = build_frame(OP_TEXT, 6, FORM_SHORT, 1'b1);
      send_span(q, 0, q.size() - 4);
      write_limit(16'd5);
      send_span(q, q.size() - 4, q.size());
      frames_sent++;

      // 64-bit length beyond a mid-size limit
      write_limit(16'd40);
      send_frame(OP_TEXT, 64'd100, FORM_EXT64, 1'b1);

      // random frames, in phases with a fresh limit each
      random_start = bytes_sent;
      phase_no     = 0;
      while (bytes_sent < random_start + RANDOM_BYTES) begin
         case (phase_no % 6)
            0:       lim = 16'd1;
            1:       lim = 16'hFFFF;
            2:       lim = MAX_TEXT_LEN_RST;
            3:       lim = 16'($urandom_range(0, 3));
            4:       lim = 16'($urandom_range(4, 40));
            default: lim = 16'($urandom_range(0, 65535));
         endcase
         write_limit(lim);
         calm        = (phase_no == 2);
         phase_start = bytes_sent;
         while (bytes_sent < phase_start + PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               op = OP_TEXT;
            end else if (pick < 65) begin
               op = OP_PING;
            end else begin
               do op = 4'($urandom_range(0, 15));
               while (op == OP_TEXT || op == OP_CLOSE || op == OP_PING);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
               len = 64'd0;
            else if (pick < 80)
               len = 64'($urandom_range(1, 12));
            else if (pick < 95)
               len = 64'($urandom_range(13, 130));
            else
               len = 64'($urandom_range(131, 400));
            if (len < 126 && $urandom_range(0, 9) < 7)
               form = FORM_SHORT;
            else
               form = ($urandom_range(0, 1) != 0) ? FORM_EXT16 : FORM_EXT64;
            send_frame(op, len, form, 1'($urandom_range(0, 1)));
         end
         phase_no++;
      end
      calm = 1'b0;

      // close, then frames that must be ignored
      send_frame(OP_CLOSE, 2, FORM_SHORT, 1'b1);
      send_frame(OP_TEXT, 3, FORM_SHORT, 1'b0);
      send_frame(OP_PING, 0, FORM_SHORT, 1'b0);

      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d frames (%0d words) under %0d limit settings: directed cases,",
               frames_sent, bytes_sent, limit_writes);
      $display("random text, ping and skipped frames, a 64-bit truncated frame and a close;"
               , " %0d events compared.", events_checked);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
sv/wsdf_pkg.sv
sv/websocket_frame_deframer_top.sv
sim/websocket_frame_deframer_checker.sv
sim/websocket_frame_deframer_top_test.sv
